// ===== rtl/lnc_pkg.sv =====
// Shared types and codes for the lattice neighbour-copy update block.
package lnc_pkg;

    // Field widths of the stream words
    localparam int SITE_W = 20;
    localparam int DIR_W  = 3;
    localparam int DRAW_W = 16;
    localparam int OP_W   = 2;
    localparam int THR_W  = 17;
    localparam int CFG_W  = 2;

    // Operation codes carried in s_tuser
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // Neighbour direction codes
    localparam logic [DIR_W-1:0] DIR_LEFT       = 3'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT      = 3'd1;
    localparam logic [DIR_W-1:0] DIR_UP         = 3'd2;
    localparam logic [DIR_W-1:0] DIR_DOWN       = 3'd3;
    localparam logic [DIR_W-1:0] DIR_UP_LEFT    = 3'd4;
    localparam logic [DIR_W-1:0] DIR_UP_RIGHT   = 3'd5;
    localparam logic [DIR_W-1:0] DIR_DOWN_LEFT  = 3'd6;
    localparam logic [DIR_W-1:0] DIR_DOWN_RIGHT = 3'd7;

    // Configuration register indexes
    localparam logic [CFG_W-1:0] CFG_GROWTH = 2'd0;
    localparam logic [CFG_W-1:0] CFG_DEATH  = 2'd1;

    // Threshold reset value: always fire
    localparam logic [THR_W-1:0] THR_ALWAYS = 17'h10000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SPLIT,
        ST_FIX,
        ST_NADDR,
        ST_READ,
        ST_DECIDE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic div;
        logic split;
        logic fix;
        logic naddr;
        logic read;
        logic commit;
    } cmd_t;

    // Datapath to controller: decode of the incoming word
    typedef struct packed {
        logic in_update;
        logic in_read;
    } status_t;

endpackage

// ===== rtl/lnc_ctrl.sv =====
// Sequencer for one item at a time plus the result-valid flag.
module lnc_ctrl import lnc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   commit;

    // State and result-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result can be committed once the output register is free or draining
    assign commit = (state_reg == ST_DECIDE) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = (out_valid_reg && !m_tready) || commit;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    if (status.in_update) begin
                        state_next = ST_DIV;
                    end else if (status.in_read) begin
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DIV: begin
                cmd.div    = 1'b1;
                state_next = ST_SPLIT;
            end
            ST_SPLIT: begin
                cmd.split  = 1'b1;
                state_next = ST_FIX;
            end
            ST_FIX: begin
                cmd.fix    = 1'b1;
                state_next = ST_NADDR;
            end
            ST_NADDR: begin
                cmd.naddr  = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                cmd.read   = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.commit = commit;
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

// ===== rtl/lnc_datapath.sv =====
// Lattice memory, neighbour address arithmetic, update rule and result register.
module lnc_datapath import lnc_pkg::*; #(
    parameter int SIDE = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    output status_t           status,
    input  logic [OP_W-1:0]   in_op,
    input  logic [SITE_W-1:0] in_site,
    input  logic [DIR_W-1:0]  in_dir,
    input  logic [DRAW_W-1:0] in_draw,
    input  logic              in_load,
    input  logic              cfg_valid,
    input  logic [CFG_W-1:0]  cfg_index,
    input  logic [THR_W-1:0]  cfg_data,
    output logic              out_cell,
    output logic              out_nbr,
    output logic              out_changed
);

    localparam int CELLS   = SIDE * SIDE;
    localparam int FULL_W  = $clog2(CELLS);
    localparam int ADDR_W  = (FULL_W > SITE_W) ? SITE_W : FULL_W;
    localparam int DEPTH   = 2 ** ADDR_W;
    localparam int CW      = $clog2(SIDE);
    localparam int RECIP_W = 31;
    localparam int FRAC    = 32;
    localparam int PROD_W  = SITE_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << FRAC) / 64'(SIDE));
    localparam logic [CW-1:0]      X_MAX = CW'(SIDE - 1);

    // Lattice store, one bit per site, contents undefined until loaded
    logic mem [0:DEPTH-1];

    logic [OP_W-1:0]   op_reg;
    logic [SITE_W-1:0] site_reg;
    logic [DIR_W-1:0]  dir_reg;
    logic [DRAW_W-1:0] draw_reg;
    logic              load_reg;
    logic              valid_reg;
    logic [THR_W-1:0]  growth_reg;
    logic [THR_W-1:0]  death_reg;
    logic [CW-1:0]     qest_reg;
    logic [CW:0]       rem_reg;
    logic [CW-1:0]     nx_reg, ny_reg;
    logic [FULL_W-1:0] rowbase_reg;
    logic              site_bit_reg, nbr_bit_reg;
    logic              out_cell_reg, out_nbr_reg, out_changed_reg;

    logic              in_range;
    logic [PROD_W-1:0] div_prod;
    logic [SITE_W:0]   q_prod;
    logic [SITE_W:0]   rem_full;
    logic [CW-1:0]     x_fix, y_fix, x_l, x_r, y_u, y_d, nx, ny;
    logic [FULL_W-1:0] nbr_full;
    logic [ADDR_W-1:0] site_addr, nbr_addr;
    logic              res_cell, res_nbr, res_changed, wr_en;

    // Input decode for the controller
    assign in_range         = 32'(in_site) < 32'(CELLS);
    assign status.in_update = in_range && (in_op == OP_UPDATE);
    assign status.in_read   = in_range && (in_op == OP_READ);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            growth_reg <= THR_ALWAYS;
            death_reg  <= THR_ALWAYS;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_GROWTH) begin
                growth_reg <= cfg_data;
            end
            if (cfg_index == CFG_DEATH) begin
                death_reg <= cfg_data;
            end
        end
    end

    // Item capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= in_op;
            site_reg  <= in_site;
            dir_reg   <= in_dir;
            draw_reg  <= in_draw;
            load_reg  <= in_load;
            valid_reg <= in_range;
        end
    end

    // Row estimate by reciprocal multiply; may be one low
    assign div_prod = PROD_W'(site_reg) * PROD_W'(RECIP);

    // Column remainder from the row estimate
    assign q_prod   = (SITE_W + 1)'(qest_reg) * (SITE_W + 1)'(SIDE);
    assign rem_full = {1'b0, site_reg} - q_prod;

    // Correct the estimate, then wrap coordinates on the torus
    always_comb begin
        if (rem_reg >= (CW + 1)'(SIDE)) begin
            x_fix = CW'(rem_reg - (CW + 1)'(SIDE));
            y_fix = qest_reg + CW'(1);
        end else begin
            x_fix = rem_reg[CW-1:0];
            y_fix = qest_reg;
        end
        x_l = (x_fix == '0)    ? X_MAX : x_fix - CW'(1);
        x_r = (x_fix == X_MAX) ? '0    : x_fix + CW'(1);
        y_u = (y_fix == '0)    ? X_MAX : y_fix - CW'(1);
        y_d = (y_fix == X_MAX) ? '0    : y_fix + CW'(1);
        case (dir_reg) inside
            DIR_LEFT, DIR_UP_LEFT, DIR_DOWN_LEFT:    nx = x_l;
            DIR_RIGHT, DIR_UP_RIGHT, DIR_DOWN_RIGHT: nx = x_r;
            default:                                 nx = x_fix;
        endcase
        case (dir_reg) inside
            DIR_UP, DIR_UP_LEFT, DIR_UP_RIGHT:       ny = y_u;
            DIR_DOWN, DIR_DOWN_LEFT, DIR_DOWN_RIGHT: ny = y_d;
            default:                                 ny = y_fix;
        endcase
    end

    // Neighbour address; indexes beyond the addressable sites alias harmlessly
    assign nbr_full  = rowbase_reg + FULL_W'(nx_reg);
    assign nbr_addr  = nbr_full[ADDR_W-1:0];
    assign site_addr = site_reg[ADDR_W-1:0];

    // Neighbour arithmetic pipeline steps
    always_ff @(posedge aclk) begin
        if (cmd.div) begin
            qest_reg <= div_prod[FRAC +: CW];
        end
        if (cmd.split) begin
            rem_reg <= rem_full[CW:0];
        end
        if (cmd.fix) begin
            nx_reg <= nx;
            ny_reg <= ny;
        end
        if (cmd.naddr) begin
            rowbase_reg <= FULL_W'(ny_reg) * FULL_W'(SIDE);
        end
    end

    // Update rule and result
    always_comb begin
        res_cell    = 1'b0;
        res_nbr     = 1'b0;
        res_changed = 1'b0;
        wr_en       = 1'b0;
        if (valid_reg) begin
            case (op_reg)
                OP_LOAD: begin
                    res_cell = load_reg;
                    wr_en    = 1'b1;
                end
                OP_UPDATE: begin
                    res_cell = site_bit_reg;
                    res_nbr  = nbr_bit_reg;
                    if (site_bit_reg && !nbr_bit_reg && ({1'b0, draw_reg} < death_reg)) begin
                        res_cell    = 1'b0;
                        res_changed = 1'b1;
                    end else if (!site_bit_reg && nbr_bit_reg &&
                                 ({1'b0, draw_reg} < growth_reg)) begin
                        res_cell    = 1'b1;
                        res_changed = 1'b1;
                    end
                    wr_en = res_changed;
                end
                OP_READ: begin
                    res_cell = site_bit_reg;
                end
                default: begin
                    res_cell = 1'b0;
                end
            endcase
        end
    end

    // Memory read and write ports
    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            site_bit_reg <= mem[site_addr];
            nbr_bit_reg  <= mem[nbr_addr];
        end
        if (cmd.commit && wr_en) begin
            mem[site_addr] <= res_cell;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_cell_reg    <= res_cell;
            out_nbr_reg     <= res_nbr;
            out_changed_reg <= res_changed;
        end
    end

    assign out_cell    = out_cell_reg;
    assign out_nbr     = out_nbr_reg;
    assign out_changed = out_changed_reg;

endmodule

// ===== rtl/lattice_neighbour_copy_update.sv =====
// Top level of the toroidal one-bit lattice with neighbor-copy updates.
//
// Holds a SIDE x SIDE one-bit lattice (site index = row*SIDE + column, wrapping
// at every edge) in an on-chip memory that is undefined until loaded. Items are
// taken one at a time. An update steps through a reciprocal multiply for the
// row, the remainder, the wrap, the row-base multiply, a read of site and
// neighbor from the two memory read ports, and a decide step that writes back.
// A read goes straight to the read step, and a load, an out-of-range site or
// an unused operation goes straight to the decide step.
// A finished result waits in the output register; the next item is accepted
// while it waits, and a further result waits in the decide step until the
// output register is taken. Thresholds are written through the cfg port
// (index 0 growth, index 1 death); the user must write them only while the
// block is idle, and the block itself does not enforce this.
module lattice_neighbour_copy_update import lnc_pkg::*; #(
    parameter int SIDE = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [39:0]       s_tdata,   // site[19:0], direction[22:20],
                                         // draw[38:23], load_value[39]
    input  logic [OP_W-1:0]   s_tuser,   // operation[1:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // cell_value[0], neighbour_value[1],
                                         // changed[2], zero[7:3]
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_index,
    input  logic [THR_W-1:0]  cfg_data
);

    cmd_t    cmd;
    status_t status;
    logic    out_cell, out_nbr, out_changed;

    assign cfg_ready = 1'b1;

    lnc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lnc_datapath #(
        .SIDE (SIDE)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .in_op       (s_tuser),
        .in_site     (s_tdata[19:0]),
        .in_dir      (s_tdata[22:20]),
        .in_draw     (s_tdata[38:23]),
        .in_load     (s_tdata[39]),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_cell    (out_cell),
        .out_nbr     (out_nbr),
        .out_changed (out_changed)
    );

    assign m_tdata = {5'b0, out_changed, out_nbr, out_cell};

    // One item in flight: an accepted word blocks the next one
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word accepted while an item is in flight");

    // A flip copies the neighbor value into the site
    a_flip_copies: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2]) |-> (m_tdata[0] == m_tdata[1]))
        else $error("changed site does not match its neighbor");

    // Result register only loads when it is free or being drained
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_tvalid || m_tready))
        else $error("result register overwritten while waiting");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the toroidal lattice neighbor-copy update block.
module tb;
    import lnc_pkg::*;

    localparam int SIDE           = 1024;
    localparam int CELLS          = SIDE * SIDE;
    localparam int DIR_LSB        = SITE_W;
    localparam int DRAW_LSB       = SITE_W + DIR_W;
    localparam int LOAD_BIT       = SITE_W + DIR_W + DRAW_W;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS    = 200;

    // Codes the package leaves out
    localparam logic [OP_W-1:0]  OP_UNUSED    = 2'd3;
    localparam logic [CFG_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic flipped;
        logic nbr_bit;
        logic site_bit;
    } site_result_t;

    // Mirror of the lattice and thresholds; predicts one result word per input word
    class lattice_mirror;
        bit               cells [int unsigned];
        logic [THR_W-1:0] growth_thr;
        logic [THR_W-1:0] death_thr;
        site_result_t     site_results_q [$];
        int               errors;

        function new();
            growth_thr = THR_ALWAYS;
            death_thr  = THR_ALWAYS;
            errors     = 0;
        endfunction

        function int pending();
            return site_results_q.size();
        endfunction

        function void set_threshold(logic [CFG_W-1:0] idx, logic [THR_W-1:0] value);
            case (idx)
                CFG_GROWTH: growth_thr = value;
                CFG_DEATH:  death_thr  = value;
                default: ;
            endcase
        endfunction

        function int unsigned neighbour_site(int unsigned site, logic [DIR_W-1:0] dir);
            int unsigned x, y, xl, xr, yu, yd, nx, ny;
            x  = site % SIDE;
            y  = site / SIDE;
            xl = (x + SIDE - 1) % SIDE;
            xr = (x + 1) % SIDE;
            yu = (y + SIDE - 1) % SIDE;
            yd = (y + 1) % SIDE;
            nx = x;
            ny = y;
            case (dir)
                DIR_LEFT:       nx = xl;
                DIR_RIGHT:      nx = xr;
                DIR_UP:         ny = yu;
                DIR_DOWN:       ny = yd;
                DIR_UP_LEFT:    begin nx = xl; ny = yu; end
                DIR_UP_RIGHT:   begin nx = xr; ny = yu; end
                DIR_DOWN_LEFT:  begin nx = xl; ny = yd; end
                default:        begin nx = xr; ny = yd; end
            endcase
            return ny * SIDE + nx;
        endfunction

        function bit cell_at(int unsigned site);
            return cells.exists(site) ? cells[site] : 1'b0;
        endfunction

        // Accepted input word: update the mirror and queue the result it causes
        function void apply_word(logic [OP_W-1:0] op, logic [39:0] word);
            site_result_t      r;
            int unsigned       site;
            logic [DIR_W-1:0]  dir;
            logic [DRAW_W-1:0] draw;
            logic              load_value;
            r          = '0;
            site       = 32'(word[SITE_W-1:0]);
            dir        = word[DIR_LSB +: DIR_W];
            draw       = word[DRAW_LSB +: DRAW_W];
            load_value = word[LOAD_BIT];
            if (site < CELLS) begin
                case (op)
                    OP_LOAD: begin
                        cells[site] = load_value;
                        r.site_bit  = load_value;
                    end
                    OP_UPDATE: begin
                        r.site_bit = cell_at(site);
                        r.nbr_bit  = cell_at(neighbour_site(site, dir));
                        if (r.site_bit && !r.nbr_bit && {1'b0, draw} < death_thr) begin
                            r.site_bit = 1'b0;
                            r.flipped  = 1'b1;
                        end else if (!r.site_bit && r.nbr_bit &&
                                     {1'b0, draw} < growth_thr) begin
                            r.site_bit = 1'b1;
                            r.flipped  = 1'b1;
                        end
                        if (r.flipped)
                            cells[site] = r.site_bit;
                    end
                    OP_READ: r.site_bit = cell_at(site);
                    default: ;
                endcase
            end
            site_results_q = {site_results_q, r};
        endfunction

        function void report(string field, int want, int got);
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        endfunction

        // Accepted result word: compare against the oldest prediction
        function void check_word(logic [7:0] word);
            site_result_t want;
            if (site_results_q.size() == 0) begin
                errors++;
                $display("%0t: result word %b expected none actual one", $time, word);
                return;
            end
            want = site_results_q.pop_front();
            if (word[0] !== want.site_bit)
                report("cell_value", int'(want.site_bit), int'(word[0]));
            if (word[1] !== want.nbr_bit)
                report("neighbour_value", int'(want.nbr_bit), int'(word[1]));
            if (word[2] !== want.flipped)
                report("changed", int'(want.flipped), int'(word[2]));
            if (word[7:3] !== 5'd0)
                report("padding", 0, int'(word[7:3]));
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [39:0]       s_tdata;
    logic [OP_W-1:0]   s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [7:0]        m_tdata;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_index;
    logic [THR_W-1:0]  cfg_data;

    lattice_mirror     mirror;
    bit                loaded [int unsigned];
    int                words_sent;
    int                idle_cycles;
    bit                s_quiet;
    bit                m_quiet;

    lattice_neighbour_copy_update #(
        .SIDE(SIDE)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Handshake monitor: results are checked, inputs and writes feed the mirror
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                mirror.check_word(m_tdata);
            if (s_tvalid && s_tready)
                mirror.apply_word(s_tuser, s_tdata);
            if (cfg_valid && cfg_ready)
                mirror.set_threshold(cfg_index, cfg_data);
        end
    end

    // Watchdog on cycles without any accepted word
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random stalls with quiet stretches
    initial begin
        int stall;
        m_tready = 1'b0;
        m_quiet  = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 29) == 0)
                m_quiet = !m_quiet;
            stall = m_quiet ? 0 : int'($urandom_range(0, 14));
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    // One input word; valid is left high so back-to-back words need no toggle
    task automatic send_word(input logic [OP_W-1:0] op, input int unsigned site,
                             input logic [DIR_W-1:0] dir, input logic [DRAW_W-1:0] draw,
                             input logic load_value);
        int gap;
        if ($urandom_range(0, 29) == 0)
            s_quiet = !s_quiet;
        gap = s_quiet ? 0 : int'($urandom_range(0, 14));
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {load_value, draw, dir, site[SITE_W-1:0]};
        do @(posedge aclk); while (s_tready !== 1'b1);
        if (op == OP_LOAD)
            loaded[site] = 1'b1;
        if (op != OP_UNUSED)
            words_sent++;
    endtask

    // Cells must be loaded before anything reads them
    task automatic ensure_loaded(input int unsigned site);
        if (!loaded.exists(site))
            send_word(OP_LOAD, site, DIR_W'($urandom_range(0, 7)),
                      DRAW_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
    endtask

    // Stop sending and let every outstanding result come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (mirror.pending() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [THR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
    endtask

    task automatic program_thresholds(input logic [THR_W-1:0] growth,
                                      input logic [THR_W-1:0] death, input bit spare);
        wait_drained();
        write_reg(CFG_GROWTH, growth);
        write_reg(CFG_DEATH, death);
        // Unmapped indexes must leave both thresholds alone
        if (spare) begin
            write_reg(CFG_SPARE_LO, THR_W'($urandom_range(0, 131071)));
            write_reg(CFG_SPARE_HI, THR_W'($urandom_range(0, 131071)));
        end
        cfg_valid <= 1'b0;
    endtask

    // Corners and edges favored so the torus wraps often
    function automatic int unsigned pick_coord();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return SIDE - 1;
            default: return $urandom_range(0, SIDE - 1);
        endcase
    endfunction

    // Wrap-around at a corner in all directions, draw extremes, both load values
    task automatic directed_words();
        int unsigned corner [4];
        int unsigned nbr;
        corner = '{0, SIDE - 1, (SIDE - 1) * SIDE, CELLS - 1};
        send_word(OP_LOAD, corner[0], DIR_LEFT, 16'hFFFF, 1'b1);
        for (int d = DIR_LEFT; d <= DIR_DOWN_RIGHT; d++) begin
            nbr = mirror.neighbour_site(corner[0], DIR_W'(d));
            ensure_loaded(nbr);
            send_word(OP_UPDATE, corner[0], DIR_W'(d), (d % 2) ? 16'hFFFF : 16'h0000,
                      1'(d % 2));
        end
        send_word(OP_LOAD, corner[3], DIR_UP, 16'h0000, 1'b0);
        send_word(OP_UPDATE, corner[3], DIR_DOWN_RIGHT, 16'h0000, 1'b0);
        for (int i = 1; i < 4; i++) begin
            ensure_loaded(corner[i]);
            send_word(OP_READ, corner[i], DIR_DOWN_RIGHT, 16'hFFFF, 1'b1);
        end
        send_word(OP_UNUSED, CELLS - 1, DIR_DOWN_RIGHT, 16'hFFFF, 1'b1);
        send_word(OP_UNUSED, 0, DIR_LEFT, 16'h0000, 1'b0);
    endtask

    // Random words clustered around a moving focus so updates meet loaded cells
    task automatic random_stretch(input int count);
        int unsigned       cx, cy, x, y, site;
        int                last_word, next_focus, kind, thr;
        logic [DIR_W-1:0]  dir;
        logic [DRAW_W-1:0] draw;
        last_word  = words_sent + count;
        next_focus = words_sent;
        cx = 0;
        cy = 0;
        while (words_sent < last_word) begin
            if (words_sent >= next_focus) begin
                cx = pick_coord();
                cy = pick_coord();
                next_focus = words_sent + 40;
            end
            x    = (cx + SIDE + $urandom_range(0, 4) - 2) % SIDE;
            y    = (cy + SIDE + $urandom_range(0, 4) - 2) % SIDE;
            site = y * SIDE + x;
            dir  = DIR_W'($urandom_range(0, 7));
            // Draws straddling a threshold now and then
            if ($urandom_range(0, 3) == 0) begin
                thr = $urandom_range(0, 1) ? int'(mirror.growth_thr) : int'(mirror.death_thr);
                thr = thr + int'($urandom_range(0, 1)) - 1;
                draw = (thr < 0) ? 16'h0000 : (thr > 65535) ? 16'hFFFF : DRAW_W'(thr);
            end else begin
                draw = DRAW_W'($urandom_range(0, 65535));
            end
            kind = int'($urandom_range(0, 99));
            if (kind < 60) begin
                ensure_loaded(site);
                ensure_loaded(mirror.neighbour_site(site, dir));
                send_word(OP_UPDATE, site, dir, draw, 1'($urandom_range(0, 1)));
            end else if (kind < 75) begin
                ensure_loaded(site);
                send_word(OP_READ, site, dir, draw, 1'($urandom_range(0, 1)));
            end else if (kind < 95) begin
                send_word(OP_LOAD, site, dir, draw, 1'($urandom_range(0, 1)));
            end else begin
                send_word(OP_UNUSED, $urandom_range(0, CELLS - 1), dir, draw,
                          1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Main sequence
    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_LOAD;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_GROWTH;
        cfg_data    = '0;
        words_sent  = 0;
        s_quiet     = 1'b0;
        mirror      = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset thresholds: both always fire
        directed_words();
        random_stretch(PHASE_WORDS / 2);

        program_thresholds(17'd32768, 17'd16384, 1'b0);
        random_stretch(PHASE_WORDS);
        program_thresholds(17'd0, THR_ALWAYS, 1'b1);
        random_stretch(PHASE_WORDS);
        program_thresholds(THR_ALWAYS, 17'd0, 1'b0);
        random_stretch(PHASE_WORDS);
        program_thresholds(17'd1, 17'd65535, 1'b0);
        random_stretch(PHASE_WORDS);
        program_thresholds(THR_W'($urandom_range(0, 65536)),
                           THR_W'($urandom_range(0, 65536)), 1'b1);
        random_stretch(PHASE_WORDS);
        program_thresholds(17'd65535, 17'd1, 1'b0);
        random_stretch(PHASE_WORDS);

        wait_drained();
        if (mirror.errors == 0 && mirror.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lnc_pkg.sv
rtl/lnc_ctrl.sv
rtl/lnc_datapath.sv
rtl/lattice_neighbour_copy_update.sv
tb/sv/tb.sv
